// ===== rtl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  // result kinds as seen on the output port
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  // character codes the parser looks for
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;

  // control bytes produced by escapes
  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_FF = 8'h0C;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_TAB = 8'h09;

  // utf-8 encoding constants
  localparam logic [15:0] UTF8_MAX1 = 16'h007F;
  localparam logic [15:0] UTF8_MAX2 = 16'h07FF;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT = 8'h80;

  // one decoded item: up to three results of one kind
  typedef struct packed {
    logic [1:0] count;   // number of results, 1 to 3
    kind_e      kind;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/jsu_front.sv =====
// Parser front end: accepts bytes, tracks string mode and builds result groups
`timescale 1ns / 1ps
`default_nettype none

module jsu_front
  import jsu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       take_i,
  input  wire logic [7:0] in_byte_i,
  output logic            cmd_push_o,
  output cmd_t            cmd_o
);

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_STR  = 3'd1,
    M_ESC  = 3'd2,
    M_HEX0 = 3'd3,
    M_HEX1 = 3'd4,
    M_HEX2 = 3'd5,
    M_HEX3 = 3'd6
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [15:0] acc_q, acc_d;
  logic [3:0]  nib;
  logic        nib_ok;
  logic [15:0] code;

  // hex digit decode, either case
  always_comb begin
    nib    = 4'd0;
    nib_ok = 1'b1;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      nib = in_byte_i[3:0];
    end else if ((in_byte_i >= 8'h41 && in_byte_i <= 8'h46) ||
                 (in_byte_i >= 8'h61 && in_byte_i <= 8'h66)) begin
      nib = in_byte_i[3:0] + 4'd9;
    end else begin
      nib_ok = 1'b0;
    end
  end

  assign code = {acc_q[11:0], nib};

  // next state and result group
  always_comb begin
    mode_d     = mode_q;
    acc_d      = acc_q;
    cmd_push_o = 1'b0;
    cmd_o      = '{count: 2'd1, kind: KIND_DATA, byte0: 8'd0, byte1: 8'd0, byte2: 8'd0};
    unique case (mode_q)
      M_STR: begin
        if (in_byte_i == CH_QUOTE) begin
          mode_d     = M_IDLE;
          cmd_push_o = 1'b1;
          cmd_o.kind = KIND_END;
        end else if (in_byte_i == CH_BSLASH) begin
          mode_d = M_ESC;
        end else if (in_byte_i == CH_NUL) begin
          mode_d     = M_IDLE;
          acc_d      = 16'd0;
          cmd_push_o = 1'b1;
          cmd_o.kind = KIND_ERR;
        end else begin
          cmd_push_o  = 1'b1;
          cmd_o.byte0 = in_byte_i;
        end
      end
      M_ESC: begin
        mode_d     = M_STR;
        cmd_push_o = 1'b1;
        unique case (in_byte_i)
          CH_QUOTE, CH_BSLASH, CH_SLASH: cmd_o.byte0 = in_byte_i;
          CH_B: cmd_o.byte0 = BYTE_BS;
          CH_F: cmd_o.byte0 = BYTE_FF;
          CH_N: cmd_o.byte0 = BYTE_LF;
          CH_R: cmd_o.byte0 = BYTE_CR;
          CH_T: cmd_o.byte0 = BYTE_TAB;
          CH_U: begin
            mode_d     = M_HEX0;
            acc_d      = 16'd0;
            cmd_push_o = 1'b0;
          end
          default: begin
            mode_d     = M_IDLE;
            acc_d      = 16'd0;
            cmd_o.kind = KIND_ERR;
          end
        endcase
      end
      M_HEX0, M_HEX1, M_HEX2, M_HEX3: begin
        if (!nib_ok) begin
          mode_d     = M_IDLE;
          acc_d      = 16'd0;
          cmd_push_o = 1'b1;
          cmd_o.kind = KIND_ERR;
        end else begin
          acc_d = code;
          if (mode_q == M_HEX3) begin
            mode_d     = M_STR;
            cmd_push_o = 1'b1;
            // utf-8 encoding of the collected code point
            if (code <= UTF8_MAX1) begin
              cmd_o.byte0 = code[7:0];
            end else if (code <= UTF8_MAX2) begin
              cmd_o.count = 2'd2;
              cmd_o.byte0 = UTF8_LEAD2 | {3'd0, code[10:6]};
              cmd_o.byte1 = UTF8_CONT | {2'd0, code[5:0]};
            end else begin
              cmd_o.count = 2'd3;
              cmd_o.byte0 = UTF8_LEAD3 | {4'd0, code[15:12]};
              cmd_o.byte1 = UTF8_CONT | {2'd0, code[11:6]};
              cmd_o.byte2 = UTF8_CONT | {2'd0, code[5:0]};
            end
          end else begin
            mode_d = mode_e'(mode_q + 3'd1);
          end
        end
      end
      default: begin
        // idle, waiting for the opening quote
        if (in_byte_i == CH_QUOTE) begin
          mode_d = M_STR;
          acc_d  = 16'd0;
        end else begin
          mode_d     = M_IDLE;
          acc_d      = 16'd0;
          cmd_push_o = 1'b1;
          cmd_o.kind = KIND_ERR;
        end
      end
    endcase
    if (!take_i) begin
      mode_d     = mode_q;
      acc_d      = acc_q;
      cmd_push_o = 1'b0;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      acc_q  <= 16'd0;
    end else begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jsu_fifo.sv =====
// Small queue of result groups between the parser and the output stage
`timescale 1ns / 1ps
`default_nettype none

module jsu_fifo
  import jsu_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem[rd_ptr_q];

  // storage write
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jsu_back.sv =====
// Output stage: splits result groups into single results behind an output register
`timescale 1ns / 1ps
`default_nettype none

module jsu_back
  import jsu_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cmd_valid_i,
  input  wire cmd_t  cmd_i,
  output logic       cmd_pop_o,
  input  wire logic  pop,
  output logic       empty,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic       last_o
);

  logic [1:0] idx_q;
  logic       out_v_q;
  logic [7:0] byte_q;
  kind_e      kind_q;
  logic       last_q;
  logic       move, is_last;
  logic [7:0] sel_byte;

  // move one result whenever the output register is free or being taken
  assign move      = cmd_valid_i && (!out_v_q || pop);
  assign is_last   = (idx_q == cmd_i.count - 2'd1);
  assign cmd_pop_o = move && is_last;

  // pick the byte of the current group
  always_comb begin
    unique case (idx_q)
      2'd0:    sel_byte = cmd_i.byte0;
      2'd1:    sel_byte = cmd_i.byte1;
      default: sel_byte = cmd_i.byte2;
    endcase
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (move) begin
      byte_q <= sel_byte;
      kind_q <= cmd_i.kind;
      last_q <= is_last;
    end
  end

  // group index and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      out_v_q <= 1'b0;
    end else begin
      if (move) begin
        idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
        out_v_q <= 1'b1;
      end else if (pop) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign empty      = !out_v_q;
  assign out_byte_o = byte_q;
  assign kind_o     = kind_q;
  assign last_o     = last_q;

endmodule

`default_nettype wire

// ===== rtl/json_string_unescape.sv =====
// Top level of the JSON quoted-string unescaper
//
//   channel  | handshake         | payload
//   ---------+-------------------+---------------------------------
//   input    | push / full       | in_byte_i[7:0]
//   result   | empty / pop       | out_byte_o[7:0], kind_o[1:0], last_o
//
// One input byte is taken per cycle while full is low; the parser decides in
// the same cycle and queues zero or one group of one to three results.
// The output stage delivers one result per cycle while pop is high or its
// register is empty, so a \u escape that encodes to three bytes keeps the
// output busy until all three are out; the group queue absorbs such bursts
// and fills only when the consumer holds off pop. Reset (rst_ni low,
// asynchronous) empties the group queue and output register; parser idles.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape
  import jsu_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      kind_o,
  output logic            last_o
);

  logic take;
  logic cmd_push, cmd_valid, cmd_pop;
  cmd_t cmd_in, cmd_head;

  assign take = push && !full;

  // parser
  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .in_byte_i  (in_byte_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // group queue
  jsu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_head)
  );

  // result serializer
  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte_o  (out_byte_o),
    .kind_o      (kind_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire
